/* hdl/skit_pkg.sv */
// Shared types and codes for the sorted key index table.
package skit_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_BITS = 32;

	typedef enum logic [2:0] {
		ACT_INSERT = 3'd0,
		ACT_FIND_EXACT = 3'd1,
		ACT_FIND_GE = 3'd2,
		ACT_FIND_LE = 3'd3,
		ACT_FIRST = 3'd4,
		ACT_NEXT = 3'd5,
		ACT_LAST = 3'd6,
		ACT_BAD = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_RD_ORD,
		S_RD_KEY,
		S_CMP,
		S_SH_RD,
		S_SH_WR,
		S_INS,
		S_E_ORD,
		S_E_KEY,
		S_OUT
	} state_t;

endpackage

/* hdl/sorted_key_index_table.sv */
// Top level: sorted key table with a binary-search sequencer over two memories.
// Searches run binary-search probes over the order and key memories; an insert searches,
// then moves order entries up one place and writes the new record; first, next and last read
// one entry; a refused insert, unknown action or find on an empty table skips to the result.
// One request at a time; in_stall stays high until the result is taken.
// Reset (arst_n, asynchronous) clears record count, cursor and control state;
// the key and order memories are undefined until written.
module sorted_key_index_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic        step_back,
	input  logic signed [31:0] search_key,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [10:0] rec_num,
	output logic signed [31:0] record_key,
	output logic [10:0] cursor_position
);
	localparam int CW = $clog2(skit_pkg::TABLE_DEPTH + 2);
	localparam int AW = $clog2(skit_pkg::TABLE_DEPTH + 1);

	logic [skit_pkg::KEY_BITS-1:0] key_mem [0:skit_pkg::TABLE_DEPTH];
	logic [CW-1:0]       ord_mem [0:skit_pkg::TABLE_DEPTH];

	skit_pkg::state_t state_q, state_n;
	skit_pkg::action_t act_q;
	logic [skit_pkg::KEY_BITS-1:0] key_q;
	logic [CW-1:0] count_q, cursor_q, lo_q, hi_q, mid_q, pos_q, idx_q;
	logic [CW-1:0] rec_q, ord_rd_q;
	logic [skit_pkg::KEY_BITS-1:0] key_rd_q;
	logic [1:0]  st_q;
	logic        miss_q, strict_q, sel_q;
	logic        ov_q;
	logic [1:0]  o_st_q;
	logic [10:0] o_rn_q, o_cp_q;
	logic [31:0] o_key_q;

	logic [CW-1:0] ord_addr;
	logic signed [skit_pkg::KEY_BITS-1:0] ks, kr;
	logic below, eq;

	assign ks = key_q;
	assign kr = key_rd_q;
	assign below = strict_q ? (kr <= ks) : (kr < ks);
	assign eq = (kr == ks);

	assign in_stall = (state_q != skit_pkg::S_IDLE) || ov_q;
	assign out_valid = ov_q;
	assign status = o_st_q;
	assign rec_num = o_rn_q;
	assign record_key = o_key_q;
	assign cursor_position = o_cp_q;

	always_comb begin
		ord_addr = mid_q;
		case (state_q)
			skit_pkg::S_SH_RD: ord_addr = idx_q - CW'(1);
			skit_pkg::S_E_ORD: ord_addr = pos_q;
			default: ord_addr = mid_q;
		endcase
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			skit_pkg::S_IDLE:
				if (in_valid && !ov_q) begin
					state_n = skit_pkg::S_OUT;
					case (skit_pkg::action_t'(action))
						skit_pkg::ACT_INSERT:
							state_n = (count_q >= CW'(skit_pkg::TABLE_DEPTH)) ? skit_pkg::S_OUT
								: skit_pkg::S_SRCH;
						skit_pkg::ACT_FIND_EXACT, skit_pkg::ACT_FIND_GE,
						skit_pkg::ACT_FIND_LE:
							state_n = (count_q == '0) ? skit_pkg::S_OUT : skit_pkg::S_SRCH;
						skit_pkg::ACT_BAD: state_n = skit_pkg::S_OUT;
						default: state_n = skit_pkg::S_E_ORD;
					endcase
				end
			skit_pkg::S_SRCH:
				state_n = (lo_q < hi_q) ? skit_pkg::S_RD_ORD : skit_pkg::S_CMP;
			skit_pkg::S_RD_ORD: state_n = skit_pkg::S_RD_KEY;
			skit_pkg::S_RD_KEY: state_n = skit_pkg::S_CMP;
			skit_pkg::S_CMP:
				if (!sel_q) state_n = skit_pkg::S_SRCH;
				else if (act_q == skit_pkg::ACT_INSERT) state_n = skit_pkg::S_SH_RD;
				else state_n = skit_pkg::S_E_ORD;
			skit_pkg::S_SH_RD:
				state_n = (idx_q > pos_q) ? skit_pkg::S_SH_WR : skit_pkg::S_INS;
			skit_pkg::S_SH_WR: state_n = skit_pkg::S_SH_RD;
			skit_pkg::S_INS: state_n = skit_pkg::S_E_ORD;
			skit_pkg::S_E_ORD: state_n = skit_pkg::S_E_KEY;
			skit_pkg::S_E_KEY: state_n = skit_pkg::S_OUT;
			skit_pkg::S_OUT: state_n = skit_pkg::S_IDLE;
			default: state_n = skit_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= skit_pkg::S_IDLE;
		else state_q <= state_n;
	end

	// memories
	always_ff @(posedge clk) begin
		ord_rd_q <= ord_mem[ord_addr[AW-1:0]];
		key_rd_q <= key_mem[ord_rd_q[AW-1:0]];
		if (state_q == skit_pkg::S_SH_WR) ord_mem[idx_q[AW-1:0]] <= ord_rd_q;
		if (state_q == skit_pkg::S_INS) begin
			ord_mem[pos_q[AW-1:0]] <= count_q;
			key_mem[count_q[AW-1:0]] <= key_q;
		end
	end

	// datapath and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cursor_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			case (state_q)
				skit_pkg::S_IDLE:
					if (in_valid && !ov_q) begin
						act_q <= skit_pkg::action_t'(action);
						key_q <= search_key[skit_pkg::KEY_BITS-1:0];
						lo_q <= CW'(1);
						hi_q <= count_q + CW'(1);
						sel_q <= 1'b0;
						strict_q <= (action == skit_pkg::ACT_INSERT)
							|| (action == skit_pkg::ACT_FIND_LE);
						st_q <= skit_pkg::ST_OK;
						miss_q <= 1'b0;
						case (skit_pkg::action_t'(action))
							skit_pkg::ACT_INSERT:
								if (count_q >= CW'(skit_pkg::TABLE_DEPTH))
									st_q <= skit_pkg::ST_FULL;
							skit_pkg::ACT_FIND_EXACT, skit_pkg::ACT_FIND_GE,
							skit_pkg::ACT_FIND_LE:
								if (count_q == '0) miss_q <= 1'b1;
							skit_pkg::ACT_FIRST: pos_q <= CW'(1);
							skit_pkg::ACT_NEXT:
								if (step_back) pos_q <= (cursor_q == '0) ? '0
									: cursor_q - CW'(1);
								else pos_q <= cursor_q + CW'(1);
							skit_pkg::ACT_LAST: pos_q <= count_q;
							default: st_q <= skit_pkg::ST_MISS;
						endcase
					end
				skit_pkg::S_SRCH: begin
					mid_q <= CW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
					if (lo_q >= hi_q) begin
						pos_q <= lo_q;
						sel_q <= 1'b1;
					end
				end
				skit_pkg::S_RD_ORD: ;
				skit_pkg::S_RD_KEY: rec_q <= ord_rd_q;
				skit_pkg::S_CMP:
					if (!sel_q) begin
						if (below) lo_q <= mid_q + CW'(1);
						else hi_q <= mid_q;
					end else begin
						if (act_q == skit_pkg::ACT_FIND_LE) pos_q <= pos_q - CW'(1);
						if (act_q == skit_pkg::ACT_INSERT) begin
							count_q <= count_q + CW'(1);
							idx_q <= count_q + CW'(1);
						end
						// exact match: verify key at the lower bound
						if (act_q == skit_pkg::ACT_FIND_EXACT) mid_q <= pos_q;
					end
				skit_pkg::S_SH_RD: ;
				skit_pkg::S_SH_WR: idx_q <= idx_q - CW'(1);
				skit_pkg::S_INS: ;
				skit_pkg::S_E_ORD: ;
				skit_pkg::S_E_KEY: rec_q <= ord_rd_q;
				skit_pkg::S_OUT: begin
					ov_q <= 1'b1;
					o_cp_q <= 11'(cursor_q);
					o_rn_q <= '0;
					o_key_q <= '0;
					o_st_q <= st_q;
					if (st_q == skit_pkg::ST_OK) begin
						if (!miss_q && pos_q >= CW'(1) && pos_q <= count_q
							&& !(act_q == skit_pkg::ACT_FIND_EXACT && !eq)) begin
							cursor_q <= pos_q;
							o_cp_q <= 11'(pos_q);
							o_rn_q <= 11'(rec_q);
							o_key_q <= 32'(kr);
						end else begin
							cursor_q <= '0;
							o_cp_q <= '0;
							o_st_q <= skit_pkg::ST_MISS;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

/* hdl/skit_checker.sv */
// Port-level checker for the sorted key index table, bound to the top level.
module skit_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [10:0] rec_num,
	input logic [10:0] cursor_position
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rec_num))
		else $error("result dropped under stall");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status");
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == 2'd1 |-> rec_num == '0)
		else $error("miss with record");
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == 2'd0 |-> rec_num != '0 && cursor_position != '0)
		else $error("ok without record");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted while busy");
endmodule

bind sorted_key_index_table skit_checker u_skit_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.rec_num(rec_num), .cursor_position(cursor_position)
);
